// ===== rtl/vsm_pkg.sv =====
package vsm_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_STAMP = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_INV_SPACING = 3'd3,
    REG_SIZE_X      = 3'd4,
    REG_SIZE_Y      = 3'd5,
    REG_SIZE_Z      = 3'd6
  } reg_e;

  localparam logic [1:0] CLS_ZERO   = 2'd0;
  localparam logic [1:0] CLS_ONE    = 2'd1;
  localparam logic [1:0] CLS_MARKED = 2'd2;

  localparam int unsigned CntW = 19;
  localparam logic [CntW-1:0] CntMax = '1;
  localparam logic [15:0] StampMax = '1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  voxel_x;
    logic [5:0]  voxel_y;
    logic [5:0]  voxel_z;
    logic [1:0]  voxel_class;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [30:0] radius;
  } item_t;

  typedef struct packed {
    logic [1:0]      class_out;
    logic [CntW-1:0] positive_total;
    logic [CntW-1:0] marked_total;
    logic [15:0]     sphere_marked;
  } result_t;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_RAD,
    FS_CX,
    FS_CY,
    FS_CZ,
    FS_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_CHECK,
    BS_READ,
    BS_WRITE,
    BS_SINGLE,
    BS_SINGLE_RD,
    BS_DONE
  } back_state_e;

endpackage

// ===== rtl/vsm_if.sv =====
interface vsm_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/voxel_sphere_marker.sv =====
// voxel grid of 2-bit classes with sphere stamping. load, stamp and read
// items each give one result beat. the front converts stamp geometry to
// cell units on one shared 32x32 multiplier (radius, then centre x, y and
// z) and queues up to two commands; the back walks the (2r+1)^3 offset
// cube one cell per cycle, but each in-bounds cell inside the sphere also
// takes a read then a write of the voxel memory.
// voxels must be loaded before being read or stamped.
module voxel_sphere_marker
  import vsm_pkg::*;
#(
  parameter int unsigned MAX_X = 64,
  parameter int unsigned MAX_Y = 64,
  parameter int unsigned MAX_Z = 64,
  parameter int unsigned MAX_RADIUS_CELLS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  vsm_if.sink         in_if,
  vsm_if.source       out_if
);

  // configuration registers
  logic [31:0] origin_x_q, origin_y_q, origin_z_q, inv_spacing_q;
  logic [6:0]  size_x_q, size_y_q, size_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      origin_z_q    <= '0;
      inv_spacing_q <= 32'd65536;
      size_x_q      <= 7'd64;
      size_y_q      <= 7'd64;
      size_z_q      <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_ORIGIN_X:    origin_x_q    <= cfg_data_i;
        REG_ORIGIN_Y:    origin_y_q    <= cfg_data_i;
        REG_ORIGIN_Z:    origin_z_q    <= cfg_data_i;
        REG_INV_SPACING: inv_spacing_q <= cfg_data_i;
        REG_SIZE_X:      size_x_q      <= cfg_data_i[6:0];
        REG_SIZE_Y:      size_y_q      <= cfg_data_i[6:0];
        REG_SIZE_Z:      size_z_q      <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // front to back command queue
  logic        cmd_valid, cmd_ready;
  logic [1:0]  cmd_op, cmd_cls;
  logic [5:0]  cmd_vx, cmd_vy, cmd_vz;
  logic [34:0] cmd_cx, cmd_cy, cmd_cz;
  logic [6:0]  cmd_cr;

  vsm_front #(
    .MaxRadiusCells(MAX_RADIUS_CELLS)
  ) u_front (
    .clk_i, .rst_ni,
    .origin_x_i(origin_x_q), .origin_y_i(origin_y_q), .origin_z_i(origin_z_q),
    .inv_spacing_i(inv_spacing_q),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready),
    .cmd_op_o(cmd_op), .cmd_vx_o(cmd_vx), .cmd_vy_o(cmd_vy), .cmd_vz_o(cmd_vz),
    .cmd_cls_o(cmd_cls), .cmd_cx_o(cmd_cx), .cmd_cy_o(cmd_cy), .cmd_cz_o(cmd_cz),
    .cmd_cr_o(cmd_cr)
  );

  vsm_back #(
    .MaxX(MAX_X), .MaxY(MAX_Y), .MaxZ(MAX_Z)
  ) u_back (
    .clk_i, .rst_ni,
    .size_x_i(size_x_q), .size_y_i(size_y_q), .size_z_i(size_z_q),
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_op_i(cmd_op), .cmd_vx_i(cmd_vx), .cmd_vy_i(cmd_vy), .cmd_vz_i(cmd_vz),
    .cmd_cls_i(cmd_cls), .cmd_cx_i(cmd_cx), .cmd_cy_i(cmd_cy), .cmd_cz_i(cmd_cz),
    .cmd_cr_i(cmd_cr),
    .res_valid_o(out_if.valid), .res_ready_i(out_if.ready), .res_data_o(out_if.data)
  );

endmodule

// ===== rtl/vsm_front.sv =====
// accepts items, converts stamp geometry to cell units, queues commands
module vsm_front
  import vsm_pkg::*;
#(
  parameter int unsigned MaxRadiusCells = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [31:0]  origin_x_i,
  input  logic [31:0]  origin_y_i,
  input  logic [31:0]  origin_z_i,
  input  logic [31:0]  inv_spacing_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  item_t        in_data_i,
  output logic         cmd_valid_o,
  input  logic         cmd_ready_i,
  output logic [1:0]   cmd_op_o,
  output logic [5:0]   cmd_vx_o,
  output logic [5:0]   cmd_vy_o,
  output logic [5:0]   cmd_vz_o,
  output logic [1:0]   cmd_cls_o,
  output logic [34:0]  cmd_cx_o,
  output logic [34:0]  cmd_cy_o,
  output logic [34:0]  cmd_cz_o,
  output logic [6:0]   cmd_cr_o
);

  localparam int unsigned QW = 2;
  localparam logic [6:0] RadMax = 7'(MaxRadiusCells);

  front_state_e st_q, st_d;
  item_t        it_q;
  logic [6:0]   cr_q, cr_d;
  logic [34:0]  cx_q, cy_q, cz_q;

  // one queue entry: op, voxel idx, class, centre cells, radius
  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  vx, vy, vz;
    logic [1:0]  cls;
    logic [34:0] cx, cy, cz;
    logic [6:0]  cr;
  } cmd_t;

  cmd_t       q_mem [QW];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       push_d;

  // shared 32x32 multiplier
  logic [31:0] mul_a;
  logic [63:0] prod;
  logic [32:0] diff;
  logic        neg;
  logic [32:0] mag;
  logic [34:0] cell_pos;
  assign prod = {32'd0, mul_a} * {32'd0, inv_spacing_i};

  always_comb begin
    diff = '0;
    unique case (st_q)
      FS_CX:   diff = {it_q.center_x[31], it_q.center_x} - {origin_x_i[31], origin_x_i};
      FS_CY:   diff = {it_q.center_y[31], it_q.center_y} - {origin_y_i[31], origin_y_i};
      FS_CZ:   diff = {it_q.center_z[31], it_q.center_z} - {origin_z_i[31], origin_z_i};
      default: diff = '0;
    endcase
    neg = diff[32];
    mag = neg ? (~diff + 33'd1) : diff;
    mul_a = (st_q == FS_RAD) ? {1'b0, it_q.radius} : mag[31:0];
    cell_pos = neg ? (~{3'b000, prod[63:32]} + 35'd1) : {3'b000, prod[63:32]};
  end

  assign in_ready_o = (st_q == FS_IDLE);
  assign push = (st_q == FS_PUSH) && (cnt_q != 2'(QW));

  always_comb begin
    st_d = st_q;
    cr_d = cr_q;
    unique case (st_q)
      FS_IDLE: if (in_valid_i) st_d = (in_data_i.opcode == OP_STAMP) ? FS_RAD : FS_PUSH;
      FS_RAD: begin
        cr_d = (prod[63:32] > {25'd0, RadMax}) ? RadMax : prod[38:32];
        st_d = FS_CX;
      end
      FS_CX:   st_d = FS_CY;
      FS_CY:   st_d = FS_CZ;
      FS_CZ:   st_d = FS_PUSH;
      FS_PUSH: if (push) st_d = FS_IDLE;
      default: st_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= FS_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      it_q <= in_data_i;
      cr_q <= '0;
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
    end else begin
      cr_q <= cr_d;
      if (st_q == FS_CX) cx_q <= cell_pos;
      if (st_q == FS_CY) cy_q <= cell_pos;
      if (st_q == FS_CZ) cz_q <= cell_pos;
    end
  end

  // command queue
  always_comb begin
    push_d.op  = it_q.opcode;
    push_d.vx  = it_q.voxel_x;
    push_d.vy  = it_q.voxel_y;
    push_d.vz  = it_q.voxel_z;
    push_d.cls = it_q.voxel_class;
    push_d.cx  = cx_q;
    push_d.cy  = cy_q;
    push_d.cz  = cz_q;
    push_d.cr  = cr_q;
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= push_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign cmd_op_o  = q_mem[rp_q].op;
  assign cmd_vx_o  = q_mem[rp_q].vx;
  assign cmd_vy_o  = q_mem[rp_q].vy;
  assign cmd_vz_o  = q_mem[rp_q].vz;
  assign cmd_cls_o = q_mem[rp_q].cls;
  assign cmd_cx_o  = q_mem[rp_q].cx;
  assign cmd_cy_o  = q_mem[rp_q].cy;
  assign cmd_cz_o  = q_mem[rp_q].cz;
  assign cmd_cr_o  = q_mem[rp_q].cr;

endmodule

// ===== rtl/vsm_back.sv =====
// voxel memory and sphere walker
module vsm_back
  import vsm_pkg::*;
#(
  parameter int unsigned MaxX = 64,
  parameter int unsigned MaxY = 64,
  parameter int unsigned MaxZ = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [6:0]  size_x_i,
  input  logic [6:0]  size_y_i,
  input  logic [6:0]  size_z_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  logic [1:0]  cmd_op_i,
  input  logic [5:0]  cmd_vx_i,
  input  logic [5:0]  cmd_vy_i,
  input  logic [5:0]  cmd_vz_i,
  input  logic [1:0]  cmd_cls_i,
  input  logic [34:0] cmd_cx_i,
  input  logic [34:0] cmd_cy_i,
  input  logic [34:0] cmd_cz_i,
  input  logic [6:0]  cmd_cr_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_data_o
);

  localparam int unsigned XW = (MaxX > 1) ? $clog2(MaxX) : 1;
  localparam int unsigned YW = (MaxY > 1) ? $clog2(MaxY) : 1;
  localparam int unsigned ZW = (MaxZ > 1) ? $clog2(MaxZ) : 1;
  localparam int unsigned AW = XW + YW + ZW;
  localparam int unsigned Depth = MaxX * MaxY * MaxZ;
  localparam logic [8:0] MaxX9 = 9'(MaxX);
  localparam logic [8:0] MaxY9 = 9'(MaxY);
  localparam logic [8:0] MaxZ9 = 9'(MaxZ);

  logic [1:0] mem [Depth];
  logic [1:0] rd_q;
  logic       we;
  logic [AW-1:0] waddr, raddr;
  logic [1:0] wdata;

  back_state_e st_q, st_d;
  logic [1:0]  op_q;
  logic [1:0]  cls_q;
  logic [34:0] cx_q, cy_q, cz_q;
  logic signed [7:0] cr_q, i_q, j_q, k_q;
  logic [13:0] c2_q;
  logic [CntW-1:0] pos_q, mrk_q;
  logic [15:0] stamp_q;
  logic        in_q;
  logic [AW-1:0] addr_q;
  logic        res_v_q;
  result_t     res_q;

  logic [8:0] ex, ey, ez;
  assign ex = ({2'b0, size_x_i} < MaxX9) ? {2'b0, size_x_i} : MaxX9;
  assign ey = ({2'b0, size_y_i} < MaxY9) ? {2'b0, size_y_i} : MaxY9;
  assign ez = ({2'b0, size_z_i} < MaxZ9) ? {2'b0, size_z_i} : MaxZ9;

  // current walk target
  logic [35:0] tx, ty, tz;
  logic [13:0] d2;
  logic        tin, last_k, last_j, last_i;
  logic [7:0]  ai, aj, ak;
  always_comb begin
    tx = {cx_q[34], cx_q} + {{28{i_q[7]}}, i_q};
    ty = {cy_q[34], cy_q} + {{28{j_q[7]}}, j_q};
    tz = {cz_q[34], cz_q} + {{28{k_q[7]}}, k_q};
    ai = i_q[7] ? -i_q : i_q;
    aj = j_q[7] ? -j_q : j_q;
    ak = k_q[7] ? -k_q : k_q;
    d2 = 14'(ai * ai) + 14'(aj * aj) + 14'(ak * ak);
    tin = !tx[35] && (tx < {27'd0, ex}) && !ty[35] && (ty < {27'd0, ey})
          && !tz[35] && (tz < {27'd0, ez}) && (d2 <= c2_q);
    last_k = (k_q == cr_q);
    last_j = (j_q == cr_q);
    last_i = (i_q == cr_q);
  end

  logic single_in;
  assign single_in = ({3'b0, cmd_vx_i} < ex) && ({3'b0, cmd_vy_i} < ey)
                     && ({3'b0, cmd_vz_i} < ez);

  assign cmd_ready_o = (st_q == BS_IDLE) && !res_v_q;
  logic take;
  assign take = cmd_valid_i && cmd_ready_o;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BS_IDLE:      if (take) st_d = (cmd_op_i == OP_STAMP) ? BS_CHECK : BS_SINGLE;
      BS_CHECK:     st_d = tin ? BS_READ : ((last_i && last_j && last_k) ? BS_DONE : BS_CHECK);
      BS_READ:      st_d = BS_WRITE;
      BS_WRITE:     st_d = (last_i && last_j && last_k) ? BS_DONE : BS_CHECK;
      BS_SINGLE:    st_d = BS_SINGLE_RD;
      BS_SINGLE_RD: st_d = BS_DONE;
      BS_DONE:      st_d = BS_IDLE;
      default:      st_d = BS_IDLE;
    endcase
  end

  // memory port control
  assign raddr = (st_q == BS_CHECK) ? {tx[XW-1:0], ty[YW-1:0], tz[ZW-1:0]} : addr_q;
  assign we = ((st_q == BS_WRITE) && (rd_q == CLS_ONE))
              || ((st_q == BS_SINGLE) && in_q && (op_q == OP_LOAD));
  assign waddr = addr_q;
  assign wdata = (st_q == BS_WRITE) ? CLS_MARKED : cls_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q   <= cmd_op_i;
      cls_q  <= cmd_cls_i;
      cx_q   <= cmd_cx_i;
      cy_q   <= cmd_cy_i;
      cz_q   <= cmd_cz_i;
      cr_q   <= {1'b0, cmd_cr_i};
      i_q    <= -{1'b0, cmd_cr_i};
      j_q    <= -{1'b0, cmd_cr_i};
      k_q    <= -{1'b0, cmd_cr_i};
      c2_q   <= 14'(cmd_cr_i * cmd_cr_i);
      in_q   <= single_in;
      addr_q <= {XW'(cmd_vx_i), YW'(cmd_vy_i), ZW'(cmd_vz_i)};
    end else begin
      if (st_q == BS_CHECK) addr_q <= raddr;
      if ((st_q == BS_CHECK && !tin) || st_q == BS_WRITE) begin
        if (last_k) begin
          k_q <= -cr_q;
          if (last_j) begin
            j_q <= -cr_q;
            i_q <= i_q + 8'sd1;
          end else begin
            j_q <= j_q + 8'sd1;
          end
        end else begin
          k_q <= k_q + 8'sd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= BS_IDLE;
      pos_q   <= '0;
      mrk_q   <= '0;
      stamp_q <= '0;
      res_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (take) stamp_q <= '0;
      if (st_q == BS_SINGLE && in_q && op_q == OP_LOAD && cls_q != CLS_ZERO
          && pos_q != CntMax) pos_q <= pos_q + CntW'(1);
      if (st_q == BS_WRITE && rd_q == CLS_ONE) begin
        if (mrk_q != CntMax) mrk_q <= mrk_q + CntW'(1);
        if (stamp_q != StampMax) stamp_q <= stamp_q + 16'd1;
      end
      if (st_q == BS_DONE) res_v_q <= 1'b1;
      else if (res_ready_i) res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BS_DONE) begin
      res_q.class_out      <= (op_q == OP_READ && in_q) ? rd_q : CLS_ZERO;
      res_q.positive_total <= pos_q;
      res_q.marked_total   <= mrk_q;
      res_q.sphere_marked  <= (op_q == OP_STAMP) ? stamp_q : 16'd0;
    end
  end

  assign res_valid_o = res_v_q;
  assign res_data_o  = res_q;

endmodule

// ===== rtl/vsm_checker.sv =====
module vsm_checker
  import vsm_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped while stalled");

  a_pos_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready ##1 out_valid |->
      out_data.positive_total >= $past(out_data.positive_total))
    else $error("positive total decreased");

  a_stamp_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.marked_total != CntMax |->
      {3'd0, out_data.sphere_marked} <= out_data.marked_total)
    else $error("stamp count exceeds marked total");

endmodule

bind voxel_sphere_marker vsm_checker u_vsm_checker (
  .clk_i, .rst_ni,
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
